// ===== src/fsge_pkg.sv =====
// Shared types and codes for the four-state gate evaluator.
`timescale 1ns / 1ps

package fsge_pkg;

  // Gate kind codes (gate_kind register).
  localparam logic [2:0] GATE_AND   = 3'd0;
  localparam logic [2:0] GATE_OR    = 3'd1;
  localparam logic [2:0] GATE_XOR   = 3'd2;
  localparam logic [2:0] GATE_EQUIV = 3'd3;
  localparam logic [2:0] GATE_IMPL  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GATE_KIND    = 2'd0;
  localparam logic [1:0] CFG_INVERT       = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_WIDTH = 2'd2;

  // Result field width (fixed by the output ports).
  localparam int unsigned ResWidth = 32;

  typedef struct packed {
    logic [2:0] kind;
    logic       invert;
  } gate_cfg_t;

  typedef struct packed {
    logic [ResWidth-1:0] value;
    logic [ResWidth-1:0] unknown;
  } res_t;

endpackage : fsge_pkg

// ===== src/four_state_gate_evaluator_unit.sv =====
// Top level of the four-state gate evaluator: lanes, merge and output buffer.
// Result: a request accepted while the output buffer is empty shows its result
//   (if any) in the next cycle.
// Throughput: one request per cycle; in_stall_o is high only while the
//   two-entry output buffer is full.
// Reset: port vectors all Z, gate_kind AND, no inversion, active width 32.
`timescale 1ns / 1ps

module four_state_gate_evaluator_unit #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned PORTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  port_index_i,
  input  logic [4:0]  part_base_i,
  input  logic [5:0]  part_length_i,
  input  logic [31:0] part_value_i,
  input  logic [31:0] part_unknown_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic [31:0] result_unknown_o
);

  localparam int unsigned WW = $clog2(WIDTH + 1);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [2:0] gate_kind_q;
  logic       invert_q;
  logic [5:0] active_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_kind_q    <= fsge_pkg::GATE_AND;
      invert_q       <= 1'b0;
      active_width_q <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fsge_pkg::CFG_GATE_KIND:    gate_kind_q    <= cfg_data_i[2:0];
        fsge_pkg::CFG_INVERT:       invert_q       <= cfg_data_i[0];
        fsge_pkg::CFG_ACTIVE_WIDTH: active_width_q <= cfg_data_i;
        default: ; // no register at this index
      endcase
    end
  end

  fsge_pkg::gate_cfg_t gate_cfg;
  assign gate_cfg.kind   = gate_kind_q;
  assign gate_cfg.invert = invert_q;

  // Effective width: zero reads as one, anything past WIDTH as WIDTH.
  logic [WW-1:0] weff;
  always_comb begin
    if (active_width_q == 6'd0) begin
      weff = WW'(1);
    end else if ({1'b0, active_width_q} > 7'(WIDTH)) begin
      weff = WW'(WIDTH);
    end else begin
      weff = WW'(active_width_q);
    end
  end

  // ---------------------------------------------------------------
  // Request decode: part window clipped to the active width
  // ---------------------------------------------------------------
  logic             in_fire;
  logic             port_ok;
  logic [5:0]       len_c;
  logic [6:0]       end_raw, end_c;
  logic [WIDTH-1:0] part_mask, active_mask;
  logic [WIDTH-1:0] wr_value, wr_unknown;
  logic [WIDTH+31:0] sh_value, sh_unknown;

  assign in_fire = in_valid_i && !in_stall_o;
  assign port_ok = {1'b0, port_index_i} < 3'(PORTS);
  assign len_c   = (part_length_i > 6'd32) ? 6'd32 : part_length_i;
  assign end_raw = 7'(part_base_i) + 7'(len_c);
  assign end_c   = (end_raw > 7'(weff)) ? 7'(weff) : end_raw;

  // A base at or above the active width leaves end_c <= base: empty window.
  for (genvar i = 0; i < WIDTH; i++) begin : g_mask
    assign part_mask[i]   = (7'(i) >= 7'(part_base_i)) && (7'(i) < end_c);
    assign active_mask[i] = 7'(i) < 7'(weff);
  end

  assign sh_value   = {{WIDTH{1'b0}}, part_value_i} << part_base_i;
  assign sh_unknown = {{WIDTH{1'b0}}, part_unknown_i} << part_base_i;
  assign wr_value   = sh_value[WIDTH-1:0];
  assign wr_unknown = sh_unknown[WIDTH-1:0];

  // ---------------------------------------------------------------
  // Port lanes
  // ---------------------------------------------------------------
  logic [PORTS-1:0] lane_sel, lane_changed;
  logic [WIDTH-1:0] lane_value   [PORTS];
  logic [WIDTH-1:0] lane_unknown [PORTS];

  for (genvar p = 0; p < PORTS; p++) begin : g_lane
    assign lane_sel[p] = port_ok && (3'(port_index_i) == 3'(p));
    fsge_lane #(
      .WIDTH(WIDTH)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (in_fire && lane_sel[p]),
      .mask_i      (part_mask),
      .wr_value_i  (wr_value),
      .wr_unknown_i(wr_unknown),
      .changed_o   (lane_changed[p]),
      .value_d_o   (lane_value[p]),
      .unknown_d_o (lane_unknown[p])
    );
  end

  // Only a request that alters its port's vector produces a result.
  logic push;
  assign push = in_fire && |(lane_changed & lane_sel);

  // Merge sees the post-write vectors of all ports.
  fsge_pkg::res_t merged;
  fsge_merge #(
    .WIDTH(WIDTH),
    .PORTS(PORTS)
  ) u_merge (
    .cfg_i        (gate_cfg),
    .active_mask_i(active_mask),
    .value_i      (lane_value),
    .unknown_i    (lane_unknown),
    .res_o        (merged)
  );

  // ---------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------
  fsge_pkg::res_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign pop   = out_valid_o && !out_stall_i;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= merged;
    end
  end

  assign in_stall_o       = (cnt_q == 2'd2);
  assign out_valid_o      = (cnt_q != 2'd0);
  assign result_value_o   = buf_q[rd_ptr_q].value;
  assign result_unknown_o = buf_q[rd_ptr_q].unknown;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  logic [31:0] active_mask32;
  assign active_mask32 = 32'(active_mask);

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && cnt_q == 2'd2))
    else $error("result pushed into a full output buffer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_value_o | result_unknown_o) & ~active_mask32) == 32'd0)
    else $error("result bits set above the active width");

  a_two_input_bit0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (gate_kind_q == fsge_pkg::GATE_EQUIV || gate_kind_q == fsge_pkg::GATE_IMPL))
    |-> (result_value_o[31:1] == 31'd0 && result_unknown_o[31:1] == 31'd0))
    else $error("two-input gate result reaches above bit 0");

endmodule : four_state_gate_evaluator_unit

// ===== src/fsge_lane.sv =====
// One input port lane: stored four-state vector, part merge and change detect.
`timescale 1ns / 1ps

module fsge_lane #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] mask_i,
  input  logic [WIDTH-1:0] wr_value_i,
  input  logic [WIDTH-1:0] wr_unknown_i,
  output logic             changed_o,
  output logic [WIDTH-1:0] value_d_o,
  output logic [WIDTH-1:0] unknown_d_o
);

  logic [WIDTH-1:0] value_q, value_d;
  logic [WIDTH-1:0] unknown_q, unknown_d;

  // Any masked bit differing in either plane counts as a change.
  assign changed_o = |(((value_q ^ wr_value_i) | (unknown_q ^ wr_unknown_i)) & mask_i);

  always_comb begin
    value_d   = value_q;
    unknown_d = unknown_q;
    if (wr_en_i) begin
      value_d   = (value_q & ~mask_i) | (wr_value_i & mask_i);
      unknown_d = (unknown_q & ~mask_i) | (wr_unknown_i & mask_i);
    end
  end

  assign value_d_o   = value_d;
  assign unknown_d_o = unknown_d;

  // Reset leaves every bit at Z.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q   <= '0;
      unknown_q <= '1;
    end else begin
      value_q   <= value_d;
      unknown_q <= unknown_d;
    end
  end

endmodule : fsge_lane

// ===== src/fsge_merge.sv =====
// Merging stage: combines all port lanes into the gate output vector.
`timescale 1ns / 1ps

module fsge_merge #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned PORTS = 4
) (
  input  fsge_pkg::gate_cfg_t cfg_i,
  input  logic [WIDTH-1:0]    active_mask_i,
  input  logic [WIDTH-1:0]    value_i   [PORTS],
  input  logic [WIDTH-1:0]    unknown_i [PORTS],
  output fsge_pkg::res_t      res_o
);

  logic [WIDTH-1:0] any0, any1, all0, all1, anyx, par;
  logic [WIDTH-1:0] res0, res1, swap, am, xbits;
  logic             a0, a1, b0, b1;

  always_comb begin
    any0 = '0;
    any1 = '0;
    all0 = '1;
    all1 = '1;
    anyx = '0;
    par  = '0;
    for (int p = 0; p < PORTS; p++) begin
      any0 |= ~unknown_i[p] & ~value_i[p];
      any1 |= ~unknown_i[p] &  value_i[p];
      all0 &= ~unknown_i[p] & ~value_i[p];
      all1 &= ~unknown_i[p] &  value_i[p];
      anyx |=  unknown_i[p];
      par  ^=  value_i[p];
    end
  end

  // Bit 0 of ports 0 and 1 for the two-input kinds; Z acts as X.
  assign a1 = ~unknown_i[0][0] &  value_i[0][0];
  assign a0 = ~unknown_i[0][0] & ~value_i[0][0];
  assign b1 = ~unknown_i[1][0] &  value_i[1][0];
  assign b0 = ~unknown_i[1][0] & ~value_i[1][0];

  always_comb begin
    res0 = '0;
    res1 = '0;
    am   = active_mask_i;
    unique case (cfg_i.kind)
      fsge_pkg::GATE_AND: begin
        res1 = all1;
        res0 = any0;
      end
      fsge_pkg::GATE_OR: begin
        res1 = any1;
        res0 = all0;
      end
      fsge_pkg::GATE_XOR: begin
        res1 = ~anyx & par;
        res0 = ~anyx & ~par;
      end
      fsge_pkg::GATE_EQUIV: begin
        res1 = WIDTH'((a1 & b1) | (a0 & b0));
        res0 = WIDTH'((a1 & b0) | (a0 & b1));
        am   = WIDTH'(1'b1);
      end
      fsge_pkg::GATE_IMPL: begin
        res1 = WIDTH'(a0 | b1);
        res0 = WIDTH'(a1 & b0);
        am   = WIDTH'(1'b1);
      end
      default: begin
        // unused kinds: every active bit X
        res0 = '0;
        res1 = '0;
      end
    endcase
    if (cfg_i.invert && (cfg_i.kind == fsge_pkg::GATE_AND || cfg_i.kind == fsge_pkg::GATE_OR
        || cfg_i.kind == fsge_pkg::GATE_XOR)) begin
      swap = res1;
      res1 = res0;
      res0 = swap;
    end else begin
      swap = '0;
    end
    res0  = res0 & am;
    res1  = res1 & am;
    xbits = am & ~(res0 | res1);
  end

  assign res_o.value   = fsge_pkg::ResWidth'(res1 | xbits);
  assign res_o.unknown = fsge_pkg::ResWidth'(xbits);

endmodule : fsge_merge
